FILE: rtl/rcd_pkg.sv
// Package for the radix conversion block: sizes, shared types and the radix clamp.
`timescale 1ns / 1ps

package rcd_pkg;

   localparam int ValueWidth  = 31;
   localparam int RadixWidth  = 5;
   localparam int DigitWidth  = 4;
   localparam int StackDepth  = 32;
   localparam int StackAddrW  = $clog2(StackDepth);
   localparam int StackCountW = $clog2(StackDepth + 1);
   localparam int StepCountW  = $clog2(ValueWidth);

   localparam logic [RadixWidth-1:0] RadixReset = 5'd10;
   localparam logic [RadixWidth-1:0] RadixMin   = 5'd2;
   localparam logic [RadixWidth-1:0] RadixMax   = 5'd16;

   // Result of one pass of the serial divider
   typedef struct packed {
      logic                  done;
      logic [ValueWidth-1:0] quotient;
      logic [DigitWidth-1:0] remainder;
   } div_result_type;

   // Commands to the digit stack
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [DigitWidth-1:0] push_digit;
   } stack_ctrl_type;

   // Clamp the programmed radix into 2..16
   function automatic logic [RadixWidth-1:0] clamp_radix(input logic [RadixWidth-1:0] r);
      logic [RadixWidth-1:0] res;
      if (r < RadixMin) begin
         res = RadixMin;
      end else if (r > RadixMax) begin
         res = RadixMax;
      end else begin
         res = r;
      end
      return res;
   endfunction

endpackage

FILE: rtl/radix_conversion_digits.sv
// Top level: converts a 31-bit value into base-2..16 digits, most significant first.
//
//   channel   dir   handshake              payload
//   req       in    req_tvalid/req_tready   tdata[30:0] value
//   rsp       out   rsp_tvalid/rsp_tready   tdata[3:0] digit, tlast last, tuser empty_res
//   csr       in    csr_we                  csr_wdata[4:0] radix
//
// Each digit takes a load and 31 shift steps in the bit-serial divider, then a push;
// popping reads each digit from the stack, then moves it into the output register;
// a zero value goes straight to the output register as the empty marker.
// One value is in work at a time; the next is taken once the last digit sits in the
// output register. A stalled output holds the pop sequence. Reset is synchronous,
// clears control state and loads radix 10.
`timescale 1ns / 1ps

module radix_conversion_digits
   import rcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [30:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [3:0] digit
   output logic                  rsp_tlast,   // last
   output logic                  rsp_tuser,   // empty_res
   input  logic                  csr_we,
   input  logic [RadixWidth-1:0] csr_wdata    // radix
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StDiv    = 3'd1;
   localparam logic [2:0] StPopRd  = 3'd2;
   localparam logic [2:0] StPopOut = 3'd3;
   localparam logic [2:0] StZero   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [RadixWidth-1:0]  radix_ff;
   logic                   out_vld_ff, out_vld_in;
   logic [DigitWidth-1:0]  out_digit_ff, out_digit_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_empty_ff, out_empty_in;
   logic                   div_start;
   logic [ValueWidth-1:0]  div_dividend;
   div_result_type         div_res;
   stack_ctrl_type         stk_ctrl;
   logic [DigitWidth-1:0]  stk_digit;
   logic [StackCountW-1:0] stk_count;
   logic                   in_xact;
   logic                   out_free;
   logic [ValueWidth-1:0]  in_value;

   assign in_value = req_tdata[ValueWidth-1:0];
   assign req_tready = (state_ff == StIdle);
   assign in_xact  = req_tvalid && req_tready;
   assign out_free = !out_vld_ff || rsp_tready;

   // Radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RadixReset;
      end else if (csr_we) begin
         radix_ff <= csr_wdata;
      end
   end

   rcd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (clamp_radix(radix_ff)),
      .result   (div_res)
   );

   rcd_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stk_ctrl),
      .rd_digit (stk_digit),
      .count    (stk_count)
   );

   // Sequencer: divide until the quotient is zero, then pop the stack; a zero value gives the empty marker
   always_comb begin
      state_in            = state_ff;
      div_start           = 1'b0;
      div_dividend        = in_value;
      stk_ctrl.push       = 1'b0;
      stk_ctrl.pop        = 1'b0;
      stk_ctrl.push_digit = div_res.remainder;
      out_vld_in          = out_vld_ff && !rsp_tready;
      out_digit_in        = out_digit_ff;
      out_last_in         = out_last_ff;
      out_empty_in        = out_empty_ff;
      unique case (state_ff)
         StIdle: begin
            if (in_xact) begin
               if (in_value == '0) begin
                  state_in = StZero;
               end else begin
                  div_start = 1'b1;
                  state_in  = StDiv;
               end
            end
         end
         StDiv: begin
            if (div_res.done) begin
               stk_ctrl.push = 1'b1;
               if (div_res.quotient == '0) begin
                  state_in = StPopRd;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_res.quotient;
               end
            end
         end
         StPopRd: begin
            if (out_free) begin
               stk_ctrl.pop = 1'b1;
               state_in     = StPopOut;
            end
         end
         StPopOut: begin
            out_vld_in   = 1'b1;
            out_digit_in = stk_digit;
            out_last_in  = (stk_count == '0);
            out_empty_in = 1'b0;
            state_in     = (stk_count == '0) ? StIdle : StPopRd;
         end
         StZero: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_digit_in = '0;
               out_last_in  = 1'b1;
               out_empty_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      out_digit_ff <= out_digit_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(8 - DigitWidth)'(0), out_digit_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_empty_ff;

endmodule

FILE: rtl/rcd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder below 16.
`timescale 1ns / 1ps

module rcd_divider
   import rcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ValueWidth-1:0] dividend,
   input  logic [RadixWidth-1:0] divisor,
   output div_result_type        result
);

   logic [ValueWidth-1:0] quot_ff, quot_in;
   logic [DigitWidth-1:0] rem_ff, rem_in;
   logic [RadixWidth-1:0] div_ff, div_in;
   logic [StepCountW-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RadixWidth-1:0] trial;
   logic [DigitWidth-1:0] diff;
   logic                  fits;

   // Shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quot_ff[ValueWidth-1]};
   assign fits  = (trial >= div_ff);
   // Remainder stays below the divisor, so four bits hold it
   assign diff  = DigitWidth'(trial - div_ff);

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = StepCountW'(ValueWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[ValueWidth-2:0], fits};
         rem_in  = fits ? diff : trial[DigitWidth-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quot_ff;
   assign result.remainder = rem_ff;

endmodule

FILE: rtl/rcd_stack.sv
// Digit stack: small memory with a fill count, registered read on pop.
`timescale 1ns / 1ps

module rcd_stack
   import rcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  stack_ctrl_type         ctrl,
   output logic [DigitWidth-1:0]  rd_digit,
   output logic [StackCountW-1:0] count
);

   logic [DigitWidth-1:0]  mem [StackDepth];
   logic [DigitWidth-1:0]  rd_digit_ff;
   logic [StackCountW-1:0] count_ff, count_in;
   logic [StackCountW-1:0] top_idx;
   logic                   can_push;

   assign top_idx  = count_ff - 1'b1;
   assign can_push = (count_ff < StackCountW'(StackDepth));

   // Fill count; a push beyond the depth is dropped
   always_comb begin
      count_in = count_ff;
      if (ctrl.push && can_push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && (count_ff != '0)) begin
         count_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (ctrl.push && can_push) begin
         mem[count_ff[StackAddrW-1:0]] <= ctrl.push_digit;
      end
      if (ctrl.pop) begin
         rd_digit_ff <= mem[top_idx[StackAddrW-1:0]];
      end
   end

   assign rd_digit = rd_digit_ff;
   assign count    = count_ff;

endmodule

FILE: rtl/rcd_checker.sv
// Port-level checker for the radix conversion block, bound to the top level.
`timescale 1ns / 1ps

module rcd_checker
   import rcd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [31:0]           req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [7:0]            rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   // No result right after reset
   a_rst_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // An empty marker is a single zero digit that closes its value
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("empty result is not a lone zero digit");

   // Digit padding stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:DigitWidth] == '0))
      else $error("nonzero padding in result");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // A zero value accepted takes the block out of idle, so it stops taking values
   a_zero_in: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[ValueWidth-1:0] == '0) |=>
         !(req_tready))
      else $error("zero value did not start a result");

endmodule

bind radix_conversion_digits rcd_checker u_rcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb_radix_conversion_digits.sv
// Testbench for radix_conversion_digits: directed and random values checked digit by digit.
`timescale 1ns / 1ps

module tb_radix_conversion_digits;
   import rcd_pkg::*;

   localparam int StallLimit   = 20000;   // cycles with no transaction before giving up
   localparam int HoldOffCycles = 1500;   // long receiver stall, longer than one full conversion
   localparam int DrainCycles  = 50;
   localparam int MaxReports   = 10;
   localparam logic [ValueWidth-1:0] ValueMax = {ValueWidth{1'b1}};

   // One expected output transaction
   typedef struct packed {
      logic [DigitWidth-1:0] digit;
      logic                  last;
      logic                  empty_res;
   } digit_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_we;
   logic [RadixWidth-1:0] csr_wdata;

   digit_result_type pending_digits [$];
   logic [RadixWidth-1:0] radix_reg;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int rsp_hold_cycles = 0;
   bit idling_on = 1'b1;

   radix_conversion_digits dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Base actually used by the block: programmed radix saturated into 2..16
   function automatic logic [RadixWidth-1:0] active_base();
      logic [RadixWidth-1:0] base;
      if (radix_reg < RadixMin) begin
         base = RadixMin;
      end else if (radix_reg > RadixMax) begin
         base = RadixMax;
      end else begin
         base = radix_reg;
      end
      return base;
   endfunction

   // Queue the digits of one value, most significant first
   function automatic void predict_digits(input logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] n;
      logic [RadixWidth-1:0] base;
      logic [DigitWidth-1:0] remainders [$];
      digit_result_type r;
      base = active_base();
      n = value;
      if (n == 0) begin
         r.digit = '0;
         r.last = 1'b1;
         r.empty_res = 1'b1;
         pending_digits.push_back(r);
      end else begin
         while (n != 0) begin
            remainders.push_back(DigitWidth'(n % base));
            n = n / base;
         end
         while (remainders.size() != 0) begin
            r.digit = remainders.pop_back();
            r.last = (remainders.size() == 0);
            r.empty_res = 1'b0;
            pending_digits.push_back(r);
         end
      end
   endfunction

   // Random value: full range, small, near a power of the base, or shifted down
   function automatic logic [ValueWidth-1:0] pick_value();
      logic [63:0] p;
      logic [ValueWidth-1:0] v;
      int k;
      case ($urandom_range(0, 3))
         0: v = ValueWidth'($urandom);
         1: v = ValueWidth'($urandom_range(0, 255));
         2: begin
            p = 64'd1;
            k = $urandom_range(1, 30);
            repeat (k) begin
               if (p * 64'(active_base()) <= 64'(ValueMax)) p = p * 64'(active_base());
            end
            v = ValueWidth'(p - 64'($urandom_range(0, 1)));
         end
         default: v = ValueWidth'($urandom >> $urandom_range(0, 31));
      endcase
      return v;
   endfunction

   // Offer one value, with an occasional idle burst ahead of it
   task automatic send_value(input logic [ValueWidth-1:0] value);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, value};
      do @(posedge clock); while (!req_tready);
      predict_digits(value);
   endtask

   // Stop offering and let every outstanding digit come back
   task automatic wait_for_digits();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digits.size() != 0);
   endtask

   // Single-cycle radix write; only called with the block idle
   task automatic program_radix(input logic [RadixWidth-1:0] radix);
      csr_we <= 1'b1;
      csr_wdata <= radix;
      @(posedge clock);
      csr_we <= 1'b0;
      radix_reg = radix;
   endtask

   // Radix out of reset, zero, one, nine, ten and the largest value
   task automatic test_reset_radix();
      send_value('0);
      send_value(ValueWidth'(1));
      send_value(ValueWidth'(9));
      send_value(ValueWidth'(10));
      send_value(ValueMax);
      wait_for_digits();
   endtask

   // Both ends of the legal radix range plus saturation below two and above sixteen
   task automatic test_radix_extremes();
      logic [RadixWidth-1:0] radix_list [6];
      radix_list = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31};
      foreach (radix_list[i]) begin
         program_radix(radix_list[i]);
         send_value(ValueMax);
         send_value(31'h2AAA_AAAA);
         send_value(ValueWidth'(active_base() - 1));
         wait_for_digits();
      end
   endtask

   // Receiver holds off long enough that the block stops taking values
   task automatic test_backpressure();
      program_radix(5'd16);
      rsp_hold_cycles = HoldOffCycles;
      repeat (6) send_value(pick_value());
      wait_for_digits();
   endtask

   // Random values over several random radix settings
   task automatic test_random_values(input int phases, input int per_phase);
      repeat (phases) begin
         program_radix(RadixWidth'($urandom_range(0, 31)));
         repeat (per_phase) send_value(pick_value());
         wait_for_digits();
      end
   endtask

   // Receiver: random stall bursts, or one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each output transaction with the oldest expected digit
   always @(posedge clock) begin
      digit_result_type got;
      digit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.digit = rsp_tdata[DigitWidth-1:0];
         got.last = rsp_tlast;
         got.empty_res = rsp_tuser;
         if (pending_digits.size() == 0) begin
            if (mismatch_count < MaxReports)
               $display("unexpected digit: digit=%0h last=%0b empty=%0b",
                        got.digit, got.last, got.empty_res);
            mismatch_count++;
         end else begin
            want = pending_digits.pop_front();
            if (got != want) begin
               if (mismatch_count < MaxReports)
                  $display("mismatch: expected digit=%0h last=%0b empty=%0b,",
                           want.digit, want.last, want.empty_res,
                           " got digit=%0h last=%0b empty=%0b",
                           got.digit, got.last, got.empty_res);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      radix_reg = RadixReset;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_radix();
      test_radix_extremes();
      test_backpressure();
      test_random_values(4, 25);
      // last stretch runs without idling on either side
      idling_on = 1'b0;
      test_random_values(1, 25);

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_digits.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/rcd_pkg.sv
rtl/rcd_divider.sv
rtl/rcd_stack.sv
rtl/radix_conversion_digits.sv
rtl/rcd_checker.sv
tb/tb_radix_conversion_digits.sv
